>>> src/mpcc_pkg.sv
// Shared types and constants for the MD5 password candidate checker.
package mpcc_pkg;

   localparam int MAX_LEN    = 10;
   localparam int IDX_W      = 48;
   localparam int DIGIT_W    = 5;
   localparam int LEN_W      = 4;
   localparam int DIGEST_W   = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int ROUNDS     = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_LO = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_HI = 2'd2;

   localparam logic [7:0] CHAR_A   = 8'h61;
   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam int         LEN_BYTE = 56;

   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;

   // Powers of 26, entry n is 26^n.
   localparam logic [IDX_W-1:0] POW26 [0:MAX_LEN] = '{
      48'd1, 48'd26, 48'd676, 48'd17576, 48'd456976, 48'd11881376,
      48'd308915776, 48'd8031810176, 48'd208827064576, 48'd5429503678976,
      48'd141167095653376
   };

   localparam logic [31:0] SINE_K [0:ROUNDS-1] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam int ROT_S [0:15] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                  4, 11, 16, 23, 6, 10, 15, 21};

   typedef struct packed {
      logic                            valid;
      logic                            oor;
      logic [LEN_W-1:0]                len;
      logic [IDX_W-1:0]                idx;
      logic [IDX_W-1:0]                rest;
      logic [MAX_LEN-1:0][DIGIT_W-1:0] digits;
   } digit_stage_type;

   typedef struct packed {
      logic              valid;
      logic              oor;
      logic [IDX_W-1:0]  idx;
      logic [31:0]       a;
      logic [31:0]       b;
      logic [31:0]       c;
      logic [31:0]       d;
      logic [15:0][31:0] w;
   } round_stage_type;

   typedef struct packed {
      logic                matched;
      logic                oor;
      logic [IDX_W-1:0]    idx;
      logic [DIGEST_W-1:0] lo;
      logic [DIGEST_W-1:0] hi;
   } result_type;

endpackage

>>> src/md5_password_candidate_check.sv
// Top level of the MD5 password candidate checker.
//
// Usage: each word on the req_ channel carries one 48-bit candidate index.
// The index is written as a base-26 lower-case password of the configured
// number of characters (most significant digit first), hashed as one padded MD5 block
// and compared with the target digest. One rsp_ word comes back per req_
// word, in order: tuser holds the match and out-of-range flags, tdata the
// echoed index and the candidate digest (zero when out of range).
// Configuration goes through csr_we/csr_index/csr_data and may change only
// while the block is idle; index 3 is ignored.
// Throughput: one word per cycle while the skid stage is empty. Stages: 1 input stage, 5 * MAX_LEN digit
// cells, 1 block build stage, 64 round cells, 1 digest stage, then the output register.
// Reset (synchronous, active high) empties every stage and sets the length
// to 1 and the target digest to zero.
// Stall: when rsp_tready is low and the output register is full, the word arriving
// at the output drops into a skid register; the chain of cells holds only once
// that skid stage is full, and req_tready falls at the same time.
module md5_password_candidate_check (
   input  logic          clock,
   input  logic          reset,
   // request word
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [47:0]   req_tdata,   // candidate_index
   // result word
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [175:0]  rsp_tdata,   // index_echo, digest_low, digest_high
   output logic [1:0]    rsp_tuser,   // matched, out_of_range
   // configuration
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [63:0]   csr_data
);

   localparam int NDC = mpcc_pkg::MAX_LEN * mpcc_pkg::DIGIT_W;

   logic [mpcc_pkg::LEN_W-1:0]    len_ff;
   logic [mpcc_pkg::DIGEST_W-1:0] tgt_lo_ff;
   logic [mpcc_pkg::DIGEST_W-1:0] tgt_hi_ff;

   logic adv;

   mpcc_pkg::digit_stage_type ds [0:NDC];
   mpcc_pkg::digit_stage_type in_ff, in_in;
   mpcc_pkg::round_stage_type rs [0:mpcc_pkg::ROUNDS];
   mpcc_pkg::round_stage_type blk_ff, blk_in;
   mpcc_pkg::result_type      dig_ff, dig_in;
   logic                      dig_valid_ff;
   mpcc_pkg::result_type      res_new;
   mpcc_pkg::result_type      rsp_ff, skid_ff;
   logic                      rsp_valid_ff, skid_valid_ff;

   logic [mpcc_pkg::LEN_W-1:0] len_c;
   logic [7:0]                 bytes [0:63];

   // hold the whole chain only while the skid stage is occupied
   assign adv        = !skid_valid_ff;
   assign req_tready = adv;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= 4'd1;
         tgt_lo_ff <= '0;
         tgt_hi_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            mpcc_pkg::CSR_LENGTH:    len_ff    <= csr_data[mpcc_pkg::LEN_W-1:0];
            mpcc_pkg::CSR_TARGET_LO: tgt_lo_ff <= csr_data;
            mpcc_pkg::CSR_TARGET_HI: tgt_hi_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // clamp the length and flag indices of 26^length and above
   always_comb begin
      if (len_ff == '0) begin
         len_c = 4'd1;
      end else if (len_ff > mpcc_pkg::LEN_W'(mpcc_pkg::MAX_LEN)) begin
         len_c = mpcc_pkg::LEN_W'(mpcc_pkg::MAX_LEN);
      end else begin
         len_c = len_ff;
      end
      in_in        = '0;
      in_in.valid  = req_tvalid;
      in_in.len    = len_c;
      in_in.idx    = req_tdata;
      in_in.rest   = req_tdata;
      in_in.oor    = req_tdata >= mpcc_pkg::POW26[len_c];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ff.valid <= 1'b0;
      end else if (adv) begin
         in_ff <= in_in;
      end
   end

   assign ds[0] = in_ff;

   // digit cells: most significant position first, five bits per digit
   for (genvar k = 0; k < NDC; k++) begin : g_digit
      mpcc_digit_cell #(
         .POS  (mpcc_pkg::MAX_LEN - 1 - k / mpcc_pkg::DIGIT_W),
         .SBIT (mpcc_pkg::DIGIT_W - 1 - k % mpcc_pkg::DIGIT_W)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .adv   (adv),
         .d_in  (ds[k]),
         .d_out (ds[k+1])
      );
   end

   // lay out the padded block: characters, pad byte, bit length
   always_comb begin
      for (int j = 0; j < 64; j++) begin
         bytes[j] = 8'h00;
      end
      for (int j = 0; j < mpcc_pkg::MAX_LEN; j++) begin
         if (mpcc_pkg::LEN_W'(j) < ds[NDC].len) begin
            bytes[j] = mpcc_pkg::CHAR_A + 8'(ds[NDC].digits[ds[NDC].len
                       - mpcc_pkg::LEN_W'(j + 1)]);
         end
      end
      for (int j = 1; j <= mpcc_pkg::MAX_LEN; j++) begin
         if (mpcc_pkg::LEN_W'(j) == ds[NDC].len) begin
            bytes[j] = mpcc_pkg::PAD_BYTE;
         end
      end
      bytes[mpcc_pkg::LEN_BYTE] = {1'b0, ds[NDC].len, 3'b000};
      blk_in       = '0;
      blk_in.valid = ds[NDC].valid;
      blk_in.oor   = ds[NDC].oor;
      blk_in.idx   = ds[NDC].idx;
      blk_in.a     = mpcc_pkg::IV_A;
      blk_in.b     = mpcc_pkg::IV_B;
      blk_in.c     = mpcc_pkg::IV_C;
      blk_in.d     = mpcc_pkg::IV_D;
      for (int i = 0; i < 16; i++) begin
         blk_in.w[i] = {bytes[4*i+3], bytes[4*i+2], bytes[4*i+1], bytes[4*i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_ff.valid <= 1'b0;
      end else if (adv) begin
         blk_ff <= blk_in;
      end
   end

   assign rs[0] = blk_ff;

   for (genvar r = 0; r < mpcc_pkg::ROUNDS; r++) begin : g_round
      mpcc_round_cell #(.RND(r)) u_cell (
         .clock (clock),
         .reset (reset),
         .adv   (adv),
         .r_in  (rs[r]),
         .r_out (rs[r+1])
      );
   end

   // add the chaining values back; report zero digest when out of range
   always_comb begin
      dig_in         = '0;
      dig_in.oor     = rs[mpcc_pkg::ROUNDS].oor;
      dig_in.idx     = rs[mpcc_pkg::ROUNDS].idx;
      if (!rs[mpcc_pkg::ROUNDS].oor) begin
         dig_in.lo = {rs[mpcc_pkg::ROUNDS].b + mpcc_pkg::IV_B,
                      rs[mpcc_pkg::ROUNDS].a + mpcc_pkg::IV_A};
         dig_in.hi = {rs[mpcc_pkg::ROUNDS].d + mpcc_pkg::IV_D,
                      rs[mpcc_pkg::ROUNDS].c + mpcc_pkg::IV_C};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dig_valid_ff <= 1'b0;
      end else if (adv) begin
         dig_valid_ff <= rs[mpcc_pkg::ROUNDS].valid;
         dig_ff       <= dig_in;
      end
   end

   always_comb begin
      res_new         = dig_ff;
      res_new.matched = !dig_ff.oor && dig_ff.lo == tgt_lo_ff && dig_ff.hi == tgt_hi_ff;
   end

   // output register with skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_tready) begin
            rsp_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (dig_valid_ff) begin
         if (!rsp_valid_ff || rsp_tready) begin
            rsp_ff       <= res_new;
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= res_new;
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.hi, rsp_ff.lo, rsp_ff.idx};
   assign rsp_tuser  = {rsp_ff.oor, rsp_ff.matched};

endmodule

>>> src/mpcc_digit_cell.sv
// One compare-and-subtract cell of the base-26 digit extraction chain.
module mpcc_digit_cell #(
   parameter int POS  = 0,
   parameter int SBIT = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  mpcc_pkg::digit_stage_type d_in,
   output mpcc_pkg::digit_stage_type d_out
);

   localparam logic [mpcc_pkg::IDX_W-1:0] STEP = mpcc_pkg::POW26[POS] << SBIT;

   mpcc_pkg::digit_stage_type stage_ff, stage_in;

   always_comb begin
      stage_in = d_in;
      // take this digit bit when the weighted step still fits
      if (d_in.rest >= STEP) begin
         stage_in.rest              = d_in.rest - STEP;
         stage_in.digits[POS][SBIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (adv) begin
         stage_ff <= stage_in;
      end
   end

   assign d_out = stage_ff;

endmodule

>>> src/mpcc_round_cell.sv
// One MD5 round cell: a single step of the compression function.
module mpcc_round_cell #(
   parameter int RND = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  mpcc_pkg::round_stage_type r_in,
   output mpcc_pkg::round_stage_type r_out
);

   localparam int GRP = RND / 16;
   localparam int G   = (GRP == 0) ? RND :
                        (GRP == 1) ? ((5 * RND + 1) % 16) :
                        (GRP == 2) ? ((3 * RND + 5) % 16) : ((7 * RND) % 16);
   localparam int S   = mpcc_pkg::ROT_S[GRP * 4 + RND % 4];

   mpcc_pkg::round_stage_type stage_ff, stage_in;
   logic [31:0] f_val;
   logic [31:0] sum;
   logic [31:0] rot;

   always_comb begin
      case (GRP)
         0:       f_val = (r_in.b & r_in.c) | (~r_in.b & r_in.d);
         1:       f_val = (r_in.d & r_in.b) | (~r_in.d & r_in.c);
         2:       f_val = r_in.b ^ r_in.c ^ r_in.d;
         default: f_val = r_in.c ^ (r_in.b | ~r_in.d);
      endcase
      sum = r_in.a + f_val + mpcc_pkg::SINE_K[RND] + r_in.w[G];
      rot = (sum << S) | (sum >> (32 - S));
      stage_in   = r_in;
      stage_in.a = r_in.d;
      stage_in.d = r_in.c;
      stage_in.c = r_in.b;
      stage_in.b = r_in.b + rot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (adv) begin
         stage_ff <= stage_in;
      end
   end

   assign r_out = stage_ff;

endmodule

>>> src/mpcc_checker.sv
// Port-level checks for the MD5 password candidate checker, bound to the top.
module mpcc_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [175:0] rsp_tdata,
   input logic [1:0]   rsp_tuser
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // a match is never reported for an index out of range
   a_match_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> !rsp_tuser[1])
      else $error("match flagged on out-of-range index");

   // out-of-range results carry a zero digest
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata[175:48] == '0)
      else $error("digest not zero for out-of-range index");

   // nothing emerges straight after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // a refused request only happens while a result word is waiting
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |-> rsp_tvalid)
      else $error("request refused with no result waiting");

endmodule

bind md5_password_candidate_check mpcc_checker u_mpcc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

>>> tb/tb_top.sv
// Testbench for the MD5 password candidate checker with an in-bench MD5 predictor.
`timescale 1ns / 1ps

module tb_top;

   typedef struct packed {
      logic                          matched;
      logic                          oor;
      logic [mpcc_pkg::IDX_W-1:0]    idx;
      logic [mpcc_pkg::DIGEST_W-1:0] lo;
      logic [mpcc_pkg::DIGEST_W-1:0] hi;
   } digest_verdict_type;

   // Pipeline depth is 118 at MAX_LEN = 10; leave a margin.
   localparam int DRAIN_CYCLES = 200;
   // register index beyond the list
   localparam logic [1:0] CSR_UNMAPPED = 2'd3;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [47:0]   req_tdata;    // candidate_index
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [175:0]  rsp_tdata;    // index_echo, digest_low, digest_high
   logic [1:0]    rsp_tuser;    // matched, out_of_range
   logic          csr_we;
   logic [1:0]    csr_index;
   logic [63:0]   csr_data;

   // Shadow copy of the registers.
   logic [3:0]                    pw_len;
   logic [mpcc_pkg::DIGEST_W-1:0] want_lo;
   logic [mpcc_pkg::DIGEST_W-1:0] want_hi;

   digest_verdict_type pending_digests[$];
   int  fail_count;
   bit  rsp_calm;                // stall-free stretch for the receiver
   bit  req_calm;

   md5_password_candidate_check uut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [31:0] rotl(logic [31:0] x, int n);
      return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
   endfunction

   // MD5 of one padded block holding len lower-case characters.
   function automatic digest_verdict_type hash_candidate(logic [47:0] idx);
      digest_verdict_type v;
      logic [7:0]  blk [0:63];
      logic [31:0] w [0:15];
      logic [31:0] a, b, c, d, f, t;
      logic [47:0] rest, limit;
      int len, g, sh;
      len = (pw_len == 0) ? 1 :
            ((pw_len > mpcc_pkg::MAX_LEN) ? mpcc_pkg::MAX_LEN : int'(pw_len));
      limit = 1;
      for (int i = 0; i < len; i++) limit = limit * 26;
      v = '0;
      v.idx = idx;
      if (idx >= limit) begin
         v.oor = 1'b1;
         return v;
      end
      for (int i = 0; i < 64; i++) blk[i] = 8'h00;
      rest = idx;
      for (int i = len - 1; i >= 0; i--) begin
         blk[i] = 8'h61 + 8'(rest % 26);
         rest = rest / 26;
      end
      blk[len] = 8'h80;
      blk[56] = 8'(len * 8);
      for (int i = 0; i < 16; i++)
         w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
      a = 32'h67452301; b = 32'hefcdab89; c = 32'h98badcfe; d = 32'h10325476;
      for (int i = 0; i < 64; i++) begin
         if (i < 16) begin
            f = (b & c) | (~b & d); g = i;
         end else if (i < 32) begin
            f = (d & b) | (~d & c); g = (5*i + 1) & 15;
         end else if (i < 48) begin
            f = b ^ c ^ d; g = (3*i + 5) & 15;
         end else begin
            f = c ^ (b | ~d); g = (7*i) & 15;
         end
         case (i >> 4)
            0: sh = (i%4 == 0) ? 7 : (i%4 == 1) ? 12 : (i%4 == 2) ? 17 : 22;
            1: sh = (i%4 == 0) ? 5 : (i%4 == 1) ? 9 : (i%4 == 2) ? 14 : 20;
            2: sh = (i%4 == 0) ? 4 : (i%4 == 1) ? 11 : (i%4 == 2) ? 16 : 23;
            default: sh = (i%4 == 0) ? 6 : (i%4 == 1) ? 10 : (i%4 == 2) ? 15 : 21;
         endcase
         t = d; d = c; c = b;
         b = b + rotl(a + f + mpcc_pkg::SINE_K[i] + w[g], sh);
         a = t;
      end
      v.lo = {b + 32'hefcdab89, a + 32'h67452301};
      v.hi = {d + 32'h10325476, c + 32'h98badcfe};
      v.matched = (v.lo == want_lo) && (v.hi == want_hi);
      return v;
   endfunction

   // Receiver: random stalls, drop a checked word from the head of the queue.
   always @(posedge clock) begin
      digest_verdict_type exp_v;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= rsp_calm || ($urandom_range(99) >= 33);
         if (rsp_tvalid && rsp_tready) begin
            if (pending_digests.size() == 0) begin
               $display("%0t: unexpected word tdata=%h tuser=%b", $time, rsp_tdata,
                        rsp_tuser);
               fail_count++;
            end else begin
               exp_v = pending_digests.pop_front();
               if (rsp_tuser[0] !== exp_v.matched) begin
                  $display("%0t: matched exp %b got %b", $time, exp_v.matched, rsp_tuser[0]);
                  fail_count++;
               end
               if (rsp_tuser[1] !== exp_v.oor) begin
                  $display("%0t: out_of_range exp %b got %b", $time, exp_v.oor, rsp_tuser[1]);
                  fail_count++;
               end
               if (rsp_tdata[47:0] !== exp_v.idx) begin
                  $display("%0t: index exp %h got %h", $time, exp_v.idx, rsp_tdata[47:0]);
                  fail_count++;
               end
               if (rsp_tdata[111:48] !== exp_v.lo) begin
                  $display("%0t: digest_low exp %h got %h", $time, exp_v.lo,
                           rsp_tdata[111:48]);
                  fail_count++;
               end
               if (rsp_tdata[175:112] !== exp_v.hi) begin
                  $display("%0t: digest_high exp %h got %h", $time, exp_v.hi,
                           rsp_tdata[175:112]);
                  fail_count++;
               end
            end
         end
      end
   end

   // Send one candidate, idling first at random; predict on acceptance.
   // Valid stays high after acceptance until the next idle or drain.
   task automatic send_candidate(logic [47:0] idx);
      while (!req_calm && $urandom_range(99) < 33) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= idx;
      do @(posedge clock); while (!req_tready);
      pending_digests.push_back(hash_candidate(idx));
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_digests.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write a register while idle and update the shadow copy.
   task automatic write_reg(logic [1:0] idx, logic [63:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         mpcc_pkg::CSR_LENGTH:    pw_len  = val[3:0];
         mpcc_pkg::CSR_TARGET_LO: want_lo = val;
         mpcc_pkg::CSR_TARGET_HI: want_hi = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_target(digest_verdict_type v);
      write_reg(mpcc_pkg::CSR_TARGET_LO, v.lo);
      write_reg(mpcc_pkg::CSR_TARGET_HI, v.hi);
   endtask

   // Extremes of each length, a planted match and both ends of the range.
   task automatic test_directed();
      digest_verdict_type hit;
      send_candidate(48'd0);
      send_candidate(48'd25);
      send_candidate(48'd26);
      send_candidate(48'hFFFF_FFFF_FFFF);
      wait_idle();
      write_reg(mpcc_pkg::CSR_LENGTH, 64'd3);
      hit = hash_candidate(48'd1234);
      set_target(hit);
      send_candidate(48'd1234);
      send_candidate(48'd1235);
      send_candidate(48'd17575);
      send_candidate(48'd17576);
      wait_idle();
      write_reg(mpcc_pkg::CSR_LENGTH, 64'd10);
      send_candidate(48'd0);
      send_candidate(48'd141167095653375);
      send_candidate(48'd141167095653376);
      send_candidate(48'h5555_5555_5555);
      wait_idle();
      // length zero acts as one, oversize lengths as the maximum
      write_reg(mpcc_pkg::CSR_LENGTH, 64'd0);
      send_candidate(48'd25);
      send_candidate(48'd26);
      wait_idle();
      write_reg(mpcc_pkg::CSR_LENGTH, 64'd15);
      send_candidate(48'd141167095653375);
      send_candidate(48'hAAAA_AAAA_AAAA);
      wait_idle();
      write_reg(CSR_UNMAPPED, 64'hDEAD_BEEF);   // ignored by the block
      send_candidate(48'd7);
      wait_idle();
   endtask

   // Random phases over several lengths; matches planted now and then.
   task automatic test_random();
      logic [47:0] idx, limit;
      digest_verdict_type hit;
      int lens [6] = '{1, 2, 5, 7, 10, 12};
      for (int p = 0; p < 6; p++) begin
         write_reg(mpcc_pkg::CSR_LENGTH, 64'(lens[p]));
         limit = 1;
         for (int i = 0; i < ((lens[p] > 10) ? 10 : lens[p]); i++) limit = limit * 26;
         hit = hash_candidate({16'd0, $urandom} % limit);
         set_target(hit);
         req_calm = (p == 2);
         rsp_calm = (p == 2);
         for (int n = 0; n < 180; n++) begin
            case ($urandom_range(9))
               0: idx = 48'({$urandom, $urandom});
               1: idx = hit.idx;
               2: idx = limit - 48'($urandom_range(1));
               default: idx = 48'({$urandom, $urandom}) % limit;
            endcase
            send_candidate(idx);
         end
         req_calm = 1'b0;
         rsp_calm = 1'b0;
         wait_idle();
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      rsp_calm   = 1'b0;
      req_calm   = 1'b0;
      fail_count = 0;
      pw_len     = 4'd1;
      want_lo    = '0;
      want_hi    = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      wait_idle();
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/mpcc_pkg.sv
src/mpcc_digit_cell.sv
src/mpcc_round_cell.sv
src/md5_password_candidate_check.sv
src/mpcc_checker.sv
tb/tb_top.sv
